/* rtl/cdd_pkg.sv */
// Shared types, codes and calendar tables for the date difference core.
package cdd_pkg;

	typedef logic [2:0] validity_t;

	localparam validity_t VAL_OK       = 3'd0;
	localparam validity_t VAL_YEAR     = 3'd1;
	localparam validity_t VAL_MONTH    = 3'd2;
	localparam validity_t VAL_LEAP_FEB = 3'd3;
	localparam validity_t VAL_DAY      = 3'd4;

	localparam logic REG_WIN_LOW  = 1'b0;
	localparam logic REG_WIN_HIGH = 1'b1;

	localparam int FIELD_W = 7;
	localparam int KEY_W   = 21;
	localparam int DBY_W   = 16;
	localparam int DOY_W   = 9;
	localparam int SUM_W   = 17;
	localparam int DIFF_W  = 17;

	// Per-date results of the first stage.
	typedef struct packed {
		logic [KEY_W-1:0] key;
		logic [DBY_W-1:0] dby;
		logic [DOY_W-1:0] doy;
		logic             month_ok;
		validity_t        code;
	} date_info_t;

	// Days in a month of a common year; month 1..12.
	function automatic logic [4:0] month_len(input logic [3:0] m);
		logic [4:0] r;
		case (m)
			4'd2: r = 5'd28;
			4'd4, 4'd6, 4'd9, 4'd11: r = 5'd30;
			default: r = 5'd31;
		endcase
		return r;
	endfunction

	// Days before the first of a month in a common year.
	function automatic logic [DOY_W-1:0] cum_days(input logic [3:0] m);
		logic [DOY_W-1:0] r;
		case (m)
			4'd1:  r = 9'd0;
			4'd2:  r = 9'd31;
			4'd3:  r = 9'd59;
			4'd4:  r = 9'd90;
			4'd5:  r = 9'd120;
			4'd6:  r = 9'd151;
			4'd7:  r = 9'd181;
			4'd8:  r = 9'd212;
			4'd9:  r = 9'd243;
			4'd10: r = 9'd273;
			4'd11: r = 9'd304;
			4'd12: r = 9'd334;
			default: r = 9'd0;
		endcase
		return r;
	endfunction

endpackage

/* rtl/calendar_date_difference_core.sv */
// Top level: three-stage pipeline computing day difference and validity of two dates.
//
// Channel   Dir  Width  Contents
// s_axis    in   48     request: begin/end year, month, day (7 bits each)
// m_axis    out  24     day_difference, begin_validity, end_validity
// cfg       in   7      year window low (index 0) / high (index 1)
//
// One request per cycle is sustained while the output does not stall.
// Stage 1 evaluates each date (keys, days before year, day of year, codes),
// stage 2 compares keys and forms per-date day totals, stage 3 subtracts and selects.
// Each stage advances when it is empty or the next one moves, so bubbles fill while
// the output stalls and no request is lost or repeated.
// arst_n clears the stage valid bits and loads the window registers with 15 and 99.
module calendar_date_difference_core import cdd_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_axis_tvalid,
	output logic                s_axis_tready,
	// begin_year[6:0], begin_month[13:7], begin_day[20:14],
	// end_year[27:21], end_month[34:28], end_day[41:35], zero[47:42]
	input  logic [47:0]         s_axis_tdata,
	output logic                m_axis_tvalid,
	input  logic                m_axis_tready,
	// day_difference[16:0], begin_validity[19:17], end_validity[22:20], zero[23]
	output logic [23:0]         m_axis_tdata,
	input  logic                cfg_wen,
	input  logic                cfg_addr,
	input  logic [FIELD_W-1:0]  cfg_wdata
);

	// Year window registers.
	logic [FIELD_W-1:0] win_lo_q;
	logic [FIELD_W-1:0] win_hi_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_lo_q <= 7'd15;
			win_hi_q <= 7'd99;
		end else if (cfg_wen) begin
			case (cfg_addr)
				REG_WIN_LOW:  win_lo_q <= cfg_wdata;
				REG_WIN_HIGH: win_hi_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// Stage advance chain.
	logic valid_s1, valid_s2, valid_s3;
	logic adv1, adv2, adv3;

	assign adv3 = !valid_s3 || m_axis_tready;
	assign adv2 = !valid_s2 || adv3;
	assign adv1 = !valid_s1 || adv2;
	assign s_axis_tready = adv1;

	// Stage 1: per-date evaluation.
	date_info_t info_b, info_e;
	date_info_t info_b_s1, info_e_s1;

	cdd_date_eval u_eval_begin (
		.year   (s_axis_tdata[6:0]),
		.month  (s_axis_tdata[13:7]),
		.day    (s_axis_tdata[20:14]),
		.win_lo (win_lo_q),
		.win_hi (win_hi_q),
		.info   (info_b)
	);

	cdd_date_eval u_eval_end (
		.year   (s_axis_tdata[27:21]),
		.month  (s_axis_tdata[34:28]),
		.day    (s_axis_tdata[41:35]),
		.win_lo (win_lo_q),
		.win_hi (win_hi_q),
		.info   (info_e)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (adv1) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv1 && s_axis_tvalid) begin
			info_b_s1 <= info_b;
			info_e_s1 <= info_e;
		end
	end

	// Stage 2: key order and day totals since 1 Jan 2000.
	logic             gt_s2, eq_s2, mok_s2;
	logic [SUM_W-1:0] sum_b_s2, sum_e_s2;
	validity_t        code_b_s2, code_e_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv2) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv2 && valid_s1) begin
			gt_s2     <= info_b_s1.key > info_e_s1.key;
			eq_s2     <= info_b_s1.key == info_e_s1.key;
			mok_s2    <= info_b_s1.month_ok && info_e_s1.month_ok;
			sum_b_s2  <= SUM_W'(info_b_s1.dby) + SUM_W'(info_b_s1.doy);
			sum_e_s2  <= SUM_W'(info_e_s1.dby) + SUM_W'(info_e_s1.doy);
			code_b_s2 <= info_b_s1.code;
			code_e_s2 <= info_e_s1.code;
		end
	end

	// Stage 3: subtract and pick the result.
	logic [SUM_W-1:0]       delta;
	logic [DIFF_W-1:0]      diff_sel;
	logic [DIFF_W-1:0]      diff_s3;
	validity_t              code_b_s3, code_e_s3;

	// wraps modulo 2^17, which is the two's complement difference
	assign delta = sum_e_s2 - sum_b_s2;

	always_comb begin
		if (!mok_s2) begin
			diff_sel = '0;                 // a month outside 1..12
		end else if (gt_s2) begin
			diff_sel = '1;                 // begin after end: -1
		end else if (eq_s2) begin
			diff_sel = '0;
		end else begin
			diff_sel = delta[DIFF_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (adv3) begin
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv3 && valid_s2) begin
			diff_s3   <= diff_sel;
			code_b_s3 <= code_b_s2;
			code_e_s3 <= code_e_s2;
		end
	end

	assign m_axis_tvalid = valid_s3;
	assign m_axis_tdata  = {1'b0, code_e_s3, code_b_s3, diff_s3};

	// A request taken always lands in stage 1.
	a_accept_fills_s1: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> valid_s1)
		else $error("accepted request missing from stage 1");

	// A blocked stage 2 keeps its contents.
	a_s2_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && !adv3 |=> valid_s2 && $stable(sum_e_s2) && $stable(sum_b_s2))
		else $error("stage 2 changed while blocked");

	// Bad month forces a zero difference in the next stage.
	a_bad_month_zero: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && adv3 && !mok_s2 |=> diff_s3 == '0)
		else $error("bad month did not give zero difference");

	// Codes stay in the defined set.
	a_code_range: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s3 |-> code_b_s3 <= VAL_DAY && code_e_s3 <= VAL_DAY)
		else $error("validity code out of range");

endmodule

/* rtl/cdd_date_eval.sv */
// First-stage evaluation of one date: sort key, day counts and validity code.
module cdd_date_eval import cdd_pkg::*; (
	input  logic [FIELD_W-1:0] year,
	input  logic [FIELD_W-1:0] month,
	input  logic [FIELD_W-1:0] day,
	input  logic [FIELD_W-1:0] win_lo,
	input  logic [FIELD_W-1:0] win_hi,
	output date_info_t         info
);

	logic             leap;
	logic             month_ok;
	logic [DBY_W-1:0] leaps_before;
	validity_t        code;

	// Year 2000+off: 2000 is leap, 2100 is not.
	assign leap     = (year[1:0] == 2'b00) && (year != 7'd100);
	assign month_ok = (month >= 7'd1) && (month <= 7'd12);

	// Leap years in 2000 .. 2000+off-1.
	assign leaps_before = DBY_W'((8'(year) + 8'd3) >> 2) - DBY_W'(year >= 7'd101);

	always_comb begin
		if (year > win_hi || year < win_lo) begin
			code = VAL_YEAR;
		end else if (!month_ok) begin
			code = VAL_MONTH;
		end else if (month == 7'd2 && leap) begin
			code = (day > 7'd29 || day == '0) ? VAL_LEAP_FEB : VAL_OK;
		end else if (day > 7'(month_len(month[3:0])) || day == '0) begin
			code = VAL_DAY;
		end else begin
			code = VAL_OK;
		end
	end

	assign info.key = KEY_W'(year) * KEY_W'(10000) + KEY_W'(month) * KEY_W'(100)
		+ KEY_W'(day);
	assign info.dby = DBY_W'(DBY_W'(year) * DBY_W'(365)) + leaps_before;
	assign info.doy = DOY_W'(day) + cum_days(month[3:0])
		+ DOY_W'(leap && month >= 7'd3);
	assign info.month_ok = month_ok;
	assign info.code     = code;

endmodule

/* tb/tb.sv */
// Testbench for the calendar date difference core: scoreboard class and stimulus top.
`timescale 1ns / 1ps

import cdd_pkg::*;

typedef struct {
	logic [DIFF_W-1:0] days;
	validity_t         begin_code;
	validity_t         end_code;
} span_result_t;

class date_span_scoreboard;
	int           win_low;
	int           win_high;
	int           errors;
	int           month_days[12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};
	span_result_t expected_spans[$];

	function new();
		win_low  = 15;
		win_high = 99;
		errors   = 0;
	endfunction

	function bit gregorian_leap(int y);
		return (y % 400 == 0) || ((y % 4 == 0) && (y % 100 != 0));
	endfunction

	function int month_length(int off, int m);
		return month_days[m - 1] + ((m == 2 && gregorian_leap(2000 + off)) ? 1 : 0);
	endfunction

	// days from 1 Jan 2000 to 1 Jan of 2000 + off
	function int days_to_year(int off);
		int n;
		int base;
		n    = 1999 + off;
		base = 1999 / 4 - 1999 / 100 + 1999 / 400;
		return 365 * off + (n / 4 - n / 100 + n / 400) - base;
	endfunction

	// month must be 1..12; day taken at face value
	function int ordinal_day(int off, int m, int d);
		int total;
		total = d;
		for (int i = 0; i < m - 1; i++)
			total += month_days[i];
		if (m >= 3)
			total += gregorian_leap(2000 + off);
		return total;
	endfunction

	// year window first, then month, then day
	function validity_t date_code(int off, int m, int d);
		if (off > win_high || off < win_low)
			return VAL_YEAR;
		if (m < 1 || m > 12)
			return VAL_MONTH;
		if (m == 2 && gregorian_leap(2000 + off))
			return (d < 1 || d > 29) ? VAL_LEAP_FEB : VAL_OK;
		if (d < 1 || d > month_days[m - 1])
			return VAL_DAY;
		return VAL_OK;
	endfunction

	function void note_request(logic [47:0] req);
		int           by, bm, bd, ey, em, ed;
		int           key_b, key_e, span;
		span_result_t r;
		by = req[6:0];
		bm = req[13:7];
		bd = req[20:14];
		ey = req[27:21];
		em = req[34:28];
		ed = req[41:35];
		key_b = by * 10000 + bm * 100 + bd;
		key_e = ey * 10000 + em * 100 + ed;
		if (bm < 1 || bm > 12 || em < 1 || em > 12)
			span = 0;
		else if (key_b > key_e)
			span = -1;
		else if (key_b == key_e)
			span = 0;
		else
			span = days_to_year(ey) - days_to_year(by)
				- ordinal_day(by, bm, bd) + ordinal_day(ey, em, ed);
		r.days       = span[DIFF_W-1:0];
		r.begin_code = date_code(by, bm, bd);
		r.end_code   = date_code(ey, em, ed);
		expected_spans.push_back(r);
	endfunction

	function void check_result(logic [23:0] res);
		span_result_t exp_r;
		if (expected_spans.size() == 0) begin
			$display("%0t: unexpected result %h", $time, res);
			errors++;
			return;
		end
		exp_r = expected_spans.pop_front();
		if (res[16:0] !== exp_r.days) begin
			$display("%0t: day_difference expected %0d actual %0d", $time,
				$signed(exp_r.days), $signed(res[16:0]));
			errors++;
		end
		if (res[19:17] !== exp_r.begin_code) begin
			$display("%0t: begin_validity expected %0d actual %0d", $time,
				exp_r.begin_code, res[19:17]);
			errors++;
		end
		if (res[22:20] !== exp_r.end_code) begin
			$display("%0t: end_validity expected %0d actual %0d", $time,
				exp_r.end_code, res[22:20]);
			errors++;
		end
	endfunction
endclass

module tb;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int PHASE_ITEMS    = 110;
	localparam int HOLD_CYCLES    = 80;

	logic         clk;
	logic         arst_n;
	logic         s_axis_tvalid;
	logic         s_axis_tready;
	// begin_year, begin_month, begin_day, end_year, end_month, end_day, zero pad
	logic [47:0]  s_axis_tdata;
	logic         m_axis_tvalid;
	logic         m_axis_tready;
	// day_difference, begin_validity, end_validity, zero pad
	logic [23:0]  m_axis_tdata;
	logic         cfg_wen;
	logic         cfg_addr;
	logic [6:0]   cfg_wdata;

	date_span_scoreboard sb;

	// idle percentages for each side; hold_len asks the receiver for a long stall
	int tx_idle_pct;
	int rx_idle_pct;
	int hold_len;
	int quiet_cycles;

	calendar_date_difference_core dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.cfg_wen       (cfg_wen),
		.cfg_addr      (cfg_addr),
		.cfg_wdata     (cfg_wdata)
	);

	always #2 clk = ~clk;

	function automatic logic [47:0] pack_dates(int by, int bm, int bd, int ey, int em, int ed);
		logic [6:0] f [6];
		f[0] = 7'(by); f[1] = 7'(bm); f[2] = 7'(bd);
		f[3] = 7'(ey); f[4] = 7'(em); f[5] = 7'(ed);
		return {6'b0, f[5], f[4], f[3], f[2], f[1], f[0]};
	endfunction

	// Mostly well-formed date pairs; some with one field pushed out of range,
	// a few with every field random over its full 7 bits.
	function automatic logic [47:0] random_request();
		int roll, by, bm, bd, ey, em, ed;
		roll = $urandom_range(99);
		by = $urandom_range(0, 99);
		bm = $urandom_range(1, 12);
		bd = $urandom_range(1, sb.month_length(by, bm));
		if (roll < 10) begin
			ey = by; em = bm; ed = bd;
		end else begin
			ey = (roll < 35) ? by : $urandom_range(0, 99);
			em = $urandom_range(1, 12);
			ed = $urandom_range(1, sb.month_length(ey, em));
		end
		if (roll >= 70 && roll < 88) begin
			case ($urandom_range(0, 3))
				0: bm = $urandom_range(0, 1) ? 0 : $urandom_range(13, 127);
				1: bd = $urandom_range(0, 1) ? 0 : sb.month_length(by, bm) + 1;
				2: em = $urandom_range(0, 1) ? 0 : $urandom_range(13, 127);
				default: ed = $urandom_range(0, 1) ? 0 : sb.month_length(ey, em) + 1;
			endcase
		end else if (roll >= 88) begin
			by = $urandom_range(0, 127); bm = $urandom_range(0, 127);
			bd = $urandom_range(0, 127); ey = $urandom_range(0, 127);
			em = $urandom_range(0, 127); ed = $urandom_range(0, 127);
		end
		return pack_dates(by, bm, bd, ey, em, ed);
	endfunction

	// Offer one request, idling first at random; returns once it is taken.
	task automatic send_request(input logic [47:0] req);
		while ($urandom_range(99) < tx_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= req;
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
	endtask

	// Stop sending and wait for every outstanding result, plus pipeline slack.
	task automatic drain_pipeline();
		s_axis_tvalid <= 1'b0;
		do
			@(posedge clk);
		while (sb.expected_spans.size() != 0);
		repeat (6) @(posedge clk);
	endtask

	task automatic write_window(input int low, input int high);
		cfg_wen   <= 1'b1;
		cfg_addr  <= REG_WIN_LOW;
		cfg_wdata <= 7'(low);
		@(posedge clk);
		cfg_addr  <= REG_WIN_HIGH;
		cfg_wdata <= 7'(high);
		@(posedge clk);
		cfg_wen   <= 1'b0;
		sb.win_low  = low;
		sb.win_high = high;
	endtask

	// Result side: random stalls, or one long hold counted here when requested.
	initial begin
		m_axis_tready = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_len > 0) begin
				m_axis_tready <= 1'b0;
				repeat (hold_len) @(posedge clk);
				hold_len = 0;
			end else begin
				m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);
			end
		end
	end

	// Both handshakes are sampled at the edge, before any driver update lands.
	always @(posedge clk) begin
		if (arst_n) begin
			if (s_axis_tvalid && s_axis_tready)
				sb.note_request(s_axis_tdata);
			if (m_axis_tvalid && m_axis_tready)
				sb.check_result(m_axis_tdata);
		end
	end

	// Watchdog: too long without any handshake on either side ends the run.
	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	initial begin
		int lows [6];
		int highs [6];
		sb            = new();
		clk           = 1'b0;
		arst_n        = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = '0;
		cfg_wen       = 1'b0;
		cfg_addr      = REG_WIN_LOW;
		cfg_wdata     = '0;
		tx_idle_pct   = 34;
		rx_idle_pct   = 54;
		hold_len      = 0;
		quiet_cycles  = 0;
		lows  = '{0, 99, 0, 99, 0, 15};
		highs = '{99, 0, 0, 99, 0, 99};
		lows[4]  = $urandom_range(0, 99);
		highs[4] = $urandom_range(0, 99);

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed requests under the reset window 15..99.
		send_request(pack_dates(15, 1, 1, 15, 1, 1));        // equal dates
		send_request(pack_dates(15, 1, 1, 99, 12, 31));
		send_request(pack_dates(99, 12, 31, 15, 1, 1));      // begin after end
		send_request(pack_dates(0, 1, 1, 99, 12, 31));       // widest span, year low
		send_request(pack_dates(0, 12, 31, 1, 1, 1));        // year boundary after 2000
		send_request(pack_dates(16, 2, 29, 16, 3, 1));       // leap Feb 29 valid
		send_request(pack_dates(16, 2, 30, 16, 2, 0));       // leap Feb day out of range
		send_request(pack_dates(17, 2, 29, 17, 3, 1));       // Feb 29 in common year
		send_request(pack_dates(20, 0, 5, 20, 1, 5));        // begin month zero
		send_request(pack_dates(20, 5, 5, 20, 13, 1));       // end month thirteen
		send_request(pack_dates(40, 12, 3, 30, 99, 3));      // bad month beats ordering
		send_request(pack_dates(20, 4, 31, 20, 4, 0));       // day past end, day zero
		send_request(pack_dates(20, 1, 99, 20, 2, 1));       // oversized day, negative span
		send_request(pack_dates(20, 12, 127, 21, 1, 1));
		send_request(pack_dates(14, 12, 31, 15, 1, 1));      // just below the window
		send_request(pack_dates(99, 12, 31, 100, 1, 1));     // just above the window
		send_request(pack_dates(127, 12, 127, 127, 12, 127));
		send_request(pack_dates(127, 127, 127, 127, 127, 127));
		send_request(pack_dates(0, 0, 0, 0, 0, 0));
		send_request(pack_dates(96, 3, 1, 96, 2, 29));
		send_request(pack_dates(50, 6, 30, 51, 6, 30));
		drain_pipeline();

		// Random phases, each under its own window; extremes and an inverted one.
		for (int p = 0; p < 6; p++) begin
			if (p == 2) begin
				tx_idle_pct = 54;
				rx_idle_pct = 34;
			end else if (p == 4) begin
				tx_idle_pct = 0;
				rx_idle_pct = 0;
			end
			write_window(lows[p], highs[p]);
			for (int i = 0; i < PHASE_ITEMS; i++) begin
				// long output stall while requests keep coming, to back up the pipe
				if (p == 4 && i == 10)
					hold_len = HOLD_CYCLES;
				send_request(random_request());
			end
			drain_pipeline();
		end

		repeat (10) @(posedge clk);
		if (sb.errors == 0 && sb.expected_spans.size() == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end
endmodule
